FILE: rtl/arp_responder_and_cache_macros.svh
// Assertion macros for the ARP responder and address cache checker.
// The macros expect signals named clk and arst_n in the scope where they are used.
`ifndef ARP_RESPONDER_AND_CACHE_MACROS_SVH
`define ARP_RESPONDER_AND_CACHE_MACROS_SVH

// Overlapping implication, sampled on the rising clock edge, disabled during reset.
`define ARPC_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("arpc checker: property violated");

// Non-overlapping implication, sampled on the rising clock edge, disabled during reset.
`define ARPC_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("arpc checker: property violated");

`endif

FILE: rtl/arpc_pkg.sv
// Package for the ARP responder and address cache: protocol constants, payload types,
// controller state and the command and status structs. Depends on nothing.
package arpc_pkg;

	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 64;

	// Register index taken from paddr[3]; registers sit on 8-byte boundaries.
	localparam logic REG_OWN_IP  = 1'b0;
	localparam logic REG_OWN_MAC = 1'b1;

	localparam logic [10:0] ARP_MIN_LEN    = 11'd28;
	localparam logic [15:0] ARP_HW_ETHER   = 16'h0001;
	localparam logic [15:0] ARP_PROTO_IPV4 = 16'h0800;
	localparam logic [7:0]  ARP_HW_LEN     = 8'd6;
	localparam logic [7:0]  ARP_PROTO_LEN  = 8'd4;
	localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
	localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
	localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;

	typedef enum logic {
		OPC_MESSAGE = 1'b0,
		OPC_LOOKUP  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		KIND_IGNORED = 3'd0,
		KIND_HANDLED = 3'd1,
		KIND_REPLY   = 3'd2,
		KIND_HIT     = 3'd3,
		KIND_REQUEST = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        opcode;
		logic [10:0] payload_length;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_addr_len;
		logic [7:0]  proto_addr_len;
		logic [15:0] arp_op;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
		logic [31:0] query_ip;
	} item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [47:0] send_dest_mac;
		logic [15:0] msg_op;
		logic [47:0] msg_sender_mac;
		logic [31:0] msg_sender_ip;
		logic [47:0] msg_target_mac;
		logic [31:0] msg_target_ip;
		logic [47:0] resolved_mac;
	} result_t;

	typedef struct packed {
		logic capture;
		logic scan_start;
		logic scan_run;
		logic load_result;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_lookup;
		logic scan_done;
	} ctrl_sts_t;

endpackage

FILE: rtl/arpc_if.sv
// Valid/ready channel interfaces for the ARP responder: one carries input items,
// the other result items. No dependencies.
interface arpc_item_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [10:0] payload_length;
	logic [15:0] hw_type;
	logic [15:0] proto_type;
	logic [7:0]  hw_addr_len;
	logic [7:0]  proto_addr_len;
	logic [15:0] arp_op;
	logic [47:0] sender_mac;
	logic [31:0] sender_ip;
	logic [31:0] target_ip;
	logic [31:0] query_ip;

	modport source (
		output valid, opcode, payload_length, hw_type, proto_type, hw_addr_len,
		output proto_addr_len, arp_op, sender_mac, sender_ip, target_ip, query_ip,
		input  ready
	);
	modport sink (
		input  valid, opcode, payload_length, hw_type, proto_type, hw_addr_len,
		input  proto_addr_len, arp_op, sender_mac, sender_ip, target_ip, query_ip,
		output ready
	);
endinterface

interface arpc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [47:0] send_dest_mac;
	logic [15:0] msg_op;
	logic [47:0] msg_sender_mac;
	logic [31:0] msg_sender_ip;
	logic [47:0] msg_target_mac;
	logic [31:0] msg_target_ip;
	logic [47:0] resolved_mac;

	modport source (
		output valid, result_kind, send_dest_mac, msg_op, msg_sender_mac,
		output msg_sender_ip, msg_target_mac, msg_target_ip, resolved_mac,
		input  ready
	);
	modport sink (
		input  valid, result_kind, send_dest_mac, msg_op, msg_sender_mac,
		input  msg_sender_ip, msg_target_mac, msg_target_ip, resolved_mac,
		output ready
	);
endinterface

FILE: rtl/arpc_ctrl.sv
// Controller state machine of the ARP responder: sequences capture, cache scan and
// result load, and owns the channel handshakes. Depends on arpc_pkg.
module arpc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	output logic                  result_valid,
	input  logic                  result_ready,
	input  arpc_pkg::ctrl_sts_t   sts,
	output arpc_pkg::ctrl_cmd_t   cmd
);
	import arpc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_lookup) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || result_ready) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

endmodule

FILE: rtl/arpc_dp.sv
// Datapath of the ARP responder: configuration registers, item capture, address cache
// memory with its scan pipeline, and the result register. Depends on arpc_pkg.
module arpc_dp #(
	parameter int unsigned CACHE_ENTRIES = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  arpc_pkg::ctrl_cmd_t                 cmd,
	output arpc_pkg::ctrl_sts_t                 sts,
	input  arpc_pkg::item_t                     item_d,
	output arpc_pkg::result_t                   result_q,
	input  logic                                cfg_wr,
	input  logic [arpc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [arpc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [arpc_pkg::APB_DATA_W-1:0]     prdata
);
	import arpc_pkg::*;

	localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CACHE_ENTRIES);

	logic [31:0]      own_ip_q;
	logic [47:0]      own_mac_q;
	item_t            item_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic             pend_s1;
	logic             hit_q;
	logic [31:0]      ip_rd_s1;
	logic [47:0]      mac_rd_s1;
	logic [47:0]      hit_mac_q;
	logic [31:0]      ip_mem  [CACHE_ENTRIES];
	logic [47:0]      mac_mem [CACHE_ENTRIES];

	logic             msg_ok;
	logic             rd_en;
	logic             wr_en;
	logic             match;
	result_t          result_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[3] == REG_OWN_MAC) begin
				own_mac_q <= pwdata[47:0];
			end else begin
				own_ip_q <= pwdata[31:0];
			end
		end
	end

	assign prdata = (paddr[3] == REG_OWN_MAC) ? {16'b0, own_mac_q} : {32'b0, own_ip_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item_d;
		end
	end

	assign msg_ok = (item_q.payload_length >= ARP_MIN_LEN) &&
	                (item_q.hw_type == ARP_HW_ETHER) &&
	                (item_q.proto_type == ARP_PROTO_IPV4) &&
	                (item_q.hw_addr_len == ARP_HW_LEN) &&
	                (item_q.proto_addr_len == ARP_PROTO_LEN) &&
	                (item_q.target_ip == own_ip_q);

	assign rd_en = cmd.scan_run && !hit_q && (idx_q != count_q);
	assign match = pend_s1 && !hit_q && (ip_rd_s1 == item_q.query_ip);
	assign wr_en = cmd.load_result && (item_q.opcode == OPC_MESSAGE) && msg_ok &&
	               (item_q.arp_op == ARP_OP_REPLY) && (count_q != CNT_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.scan_start) begin
				idx_q   <= '0;
				pend_s1 <= 1'b0;
				hit_q   <= 1'b0;
			end else if (cmd.scan_run) begin
				pend_s1 <= rd_en;
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ip_rd_s1  <= ip_mem[idx_q[IDX_W-1:0]];
			mac_rd_s1 <= mac_mem[idx_q[IDX_W-1:0]];
		end
		if (wr_en) begin
			ip_mem[count_q[IDX_W-1:0]]  <= item_q.sender_ip;
			mac_mem[count_q[IDX_W-1:0]] <= item_q.sender_mac;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run && match) begin
			hit_mac_q <= mac_rd_s1;
		end
	end

	assign sts.is_lookup = (item_q.opcode == OPC_LOOKUP);
	assign sts.scan_done = hit_q || (!pend_s1 && (idx_q == count_q));

	always_comb begin
		result_d              = '0;
		result_d.result_kind  = KIND_IGNORED;
		result_d.resolved_mac = MAC_BCAST;
		if (item_q.opcode == OPC_LOOKUP) begin
			if (hit_q) begin
				result_d.result_kind  = KIND_HIT;
				result_d.resolved_mac = hit_mac_q;
			end else begin
				result_d.result_kind    = KIND_REQUEST;
				result_d.send_dest_mac  = MAC_BCAST;
				result_d.msg_op         = ARP_OP_REQUEST;
				result_d.msg_sender_mac = own_mac_q;
				result_d.msg_sender_ip  = own_ip_q;
				result_d.msg_target_ip  = item_q.query_ip;
			end
		end else if (msg_ok) begin
			if (item_q.arp_op == ARP_OP_REQUEST) begin
				result_d.result_kind    = KIND_REPLY;
				result_d.send_dest_mac  = item_q.sender_mac;
				result_d.msg_op         = ARP_OP_REPLY;
				result_d.msg_sender_mac = own_mac_q;
				result_d.msg_sender_ip  = own_ip_q;
				result_d.msg_target_mac = item_q.sender_mac;
				result_d.msg_target_ip  = item_q.sender_ip;
			end else begin
				result_d.result_kind = KIND_HANDLED;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			result_q <= result_d;
		end
	end

endmodule

FILE: rtl/arp_responder_and_cache.sv
// ARP responder with IP-to-MAC address cache. A received message is captured, passes the
// DECODE state and is loaded into the result register in DONE, so a new message is taken only
// after the last one is loaded; a lookup scans the cache from entry zero in SCAN, one entry a
// cycle on the cache memory read port, until a hit or the last filled entry, then loads in DONE.
// The next transfer is taken in the cycle after a result is loaded, even while that result waits.
// Asynchronous active-low reset clears the control state, entry count and configuration.
module arp_responder_and_cache #(
	parameter int unsigned CACHE_ENTRIES = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	arpc_item_if.sink                           item,
	arpc_result_if.source                       result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [arpc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [arpc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [arpc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import arpc_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;
	item_t     item_pl;
	result_t   result_pl;
	logic      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	assign item_pl.opcode         = item.opcode;
	assign item_pl.payload_length = item.payload_length;
	assign item_pl.hw_type        = item.hw_type;
	assign item_pl.proto_type     = item.proto_type;
	assign item_pl.hw_addr_len    = item.hw_addr_len;
	assign item_pl.proto_addr_len = item.proto_addr_len;
	assign item_pl.arp_op         = item.arp_op;
	assign item_pl.sender_mac     = item.sender_mac;
	assign item_pl.sender_ip      = item.sender_ip;
	assign item_pl.target_ip      = item.target_ip;
	assign item_pl.query_ip       = item.query_ip;

	arpc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	arpc_dp #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.item_d   (item_pl),
		.result_q (result_pl),
		.cfg_wr   (cfg_wr),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata)
	);

	assign result.result_kind    = result_pl.result_kind;
	assign result.send_dest_mac  = result_pl.send_dest_mac;
	assign result.msg_op         = result_pl.msg_op;
	assign result.msg_sender_mac = result_pl.msg_sender_mac;
	assign result.msg_sender_ip  = result_pl.msg_sender_ip;
	assign result.msg_target_mac = result_pl.msg_target_mac;
	assign result.msg_target_ip  = result_pl.msg_target_ip;
	assign result.resolved_mac   = result_pl.resolved_mac;

endmodule

FILE: rtl/arpc_checker.sv
// Port-level checker for the ARP responder and its bind to the top level.
// Depends on arpc_pkg and arp_responder_and_cache_macros.svh.
`include "arp_responder_and_cache_macros.svh"

module arpc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                item_valid,
	input logic                                item_ready,
	input logic                                result_valid,
	input logic                                result_ready,
	input logic                                psel,
	input logic                                penable,
	input logic                                pwrite,
	input logic [arpc_pkg::APB_ADDR_W-1:0]     paddr,
	input logic [arpc_pkg::APB_DATA_W-1:0]     pwdata,
	input logic [arpc_pkg::APB_DATA_W-1:0]     prdata
);
	import arpc_pkg::*;

	logic item_xfer;
	logic ip_write;

	assign item_xfer = item_valid && item_ready;
	assign ip_write  = psel && penable && pwrite && (paddr[3] == REG_OWN_IP);

	// A pending result stays offered until its transfer.
	`ARPC_ASSERT_NXT(a_result_held, result_valid && !result_ready, result_valid)
	// The block works on one item at a time, so it is busy right after a transfer.
	`ARPC_ASSERT_NXT(a_busy_after_item, item_xfer, !item_ready)
	// A new result is only loaded while the block is busy with an item.
	`ARPC_ASSERT_IMP(a_result_from_work, $rose(result_valid), $past(!item_ready))
	// The own IP register reads back what was last written.
	`ARPC_ASSERT_NXT(a_ip_readback, ip_write,
		paddr[3] != REG_OWN_IP || prdata == {32'b0, $past(pwdata[31:0])})

endmodule

bind arp_responder_and_cache arpc_checker u_arpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for arp_responder_and_cache: filtering, replies, cache fill and lookups.
// Depends on arpc_pkg, the arpc_item_if / arpc_result_if interfaces and the block itself.
module testbench;
	import arpc_pkg::*;

	localparam int CACHE_DEPTH = 128;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	arpc_item_if item_ch();
	arpc_result_if result_ch();

	arp_responder_and_cache #(.CACHE_ENTRIES(CACHE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [31:0] station_ip = '0;
	logic [47:0] station_mac = '0;
	logic [31:0] known_ips[$];
	logic [47:0] known_macs[$];
	result_t awaited_results[$];

	int mismatches = 0;
	int items_sent = 0;
	int settings_used = 0;
	int cycle_count = 0;
	int kinds_seen[5] = '{default: 0};
	bit quiet = 1'b0;
	logic calm;

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic result_t resolve_outcome(input item_t it);
		result_t r;
		int i;
		r = '0;
		r.resolved_mac = MAC_BCAST;
		if (it.opcode == OPC_LOOKUP) begin
			for (i = 0; i < known_ips.size(); i++) begin
				if (known_ips[i] == it.query_ip) begin
					r.result_kind = KIND_HIT;
					r.resolved_mac = known_macs[i];
					return r;
				end
			end
			r.result_kind = KIND_REQUEST;
			r.send_dest_mac = MAC_BCAST;
			r.msg_op = ARP_OP_REQUEST;
			r.msg_sender_mac = station_mac;
			r.msg_sender_ip = station_ip;
			r.msg_target_ip = it.query_ip;
			return r;
		end
		if (it.payload_length < ARP_MIN_LEN || it.hw_type != ARP_HW_ETHER ||
				it.proto_type != ARP_PROTO_IPV4 || it.hw_addr_len != ARP_HW_LEN ||
				it.proto_addr_len != ARP_PROTO_LEN || it.target_ip != station_ip) begin
			r.result_kind = KIND_IGNORED;
			return r;
		end
		if (it.arp_op == ARP_OP_REQUEST) begin
			r.result_kind = KIND_REPLY;
			r.send_dest_mac = it.sender_mac;
			r.msg_op = ARP_OP_REPLY;
			r.msg_sender_mac = station_mac;
			r.msg_sender_ip = station_ip;
			r.msg_target_mac = it.sender_mac;
			r.msg_target_ip = it.sender_ip;
			return r;
		end
		if (it.arp_op == ARP_OP_REPLY && known_ips.size() < CACHE_DEPTH) begin
			known_ips.push_back(it.sender_ip);
			known_macs.push_back(it.sender_mac);
		end
		r.result_kind = KIND_HANDLED;
		return r;
	endfunction

	function automatic logic [47:0] rand_mac();
		logic [63:0] bits;
		int pick;
		bits = {$urandom, $urandom};
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return MAC_BCAST;
		if (pick == 1)
			return '0;
		return bits[47:0];
	endfunction

	function automatic logic [31:0] pick_ip(input int known_pct);
		if (known_ips.size() > 0 && $urandom_range(0, 99) < known_pct)
			return known_ips[$urandom_range(0, known_ips.size() - 1)];
		return $urandom;
	endfunction

	function automatic item_t random_item();
		logic [223:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return item_t'(bits[$bits(item_t)-1:0]);
	endfunction

	function automatic item_t make_message(input logic [15:0] op, input logic [47:0] mac,
			input logic [31:0] ip);
		item_t r;
		r = random_item();
		r.opcode = OPC_MESSAGE;
		r.payload_length = $urandom_range(ARP_MIN_LEN, 2047);
		r.hw_type = ARP_HW_ETHER;
		r.proto_type = ARP_PROTO_IPV4;
		r.hw_addr_len = ARP_HW_LEN;
		r.proto_addr_len = ARP_PROTO_LEN;
		r.arp_op = op;
		r.sender_mac = mac;
		r.sender_ip = ip;
		r.target_ip = station_ip;
		return r;
	endfunction

	function automatic item_t make_lookup(input logic [31:0] ip);
		item_t r;
		r = random_item();
		r.opcode = OPC_LOOKUP;
		r.query_ip = ip;
		return r;
	endfunction

	function automatic item_t break_message(input item_t good);
		item_t r;
		logic [31:0] flip;
		r = good;
		flip = $urandom_range(1, 32'hFFFF_FFFF);
		case ($urandom_range(0, 5))
			0: r.payload_length = $urandom_range(0, ARP_MIN_LEN - 1);
			1: r.hw_type = r.hw_type ^ (flip[15:0] | 16'h8000);
			2: r.proto_type = r.proto_type ^ (flip[15:0] | 16'h0001);
			3: r.hw_addr_len = r.hw_addr_len ^ (flip[7:0] | 8'h10);
			4: r.proto_addr_len = r.proto_addr_len ^ (flip[7:0] | 8'h01);
			default: r.target_ip = r.target_ip ^ flip;
		endcase
		return r;
	endfunction

	function automatic void compare_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_item(input item_t it);
		result_t outcome;
		if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= it.opcode;
		item_ch.payload_length <= it.payload_length;
		item_ch.hw_type <= it.hw_type;
		item_ch.proto_type <= it.proto_type;
		item_ch.hw_addr_len <= it.hw_addr_len;
		item_ch.proto_addr_len <= it.proto_addr_len;
		item_ch.arp_op <= it.arp_op;
		item_ch.sender_mac <= it.sender_mac;
		item_ch.sender_ip <= it.sender_ip;
		item_ch.target_ip <= it.target_ip;
		item_ch.query_ip <= it.query_ip;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		outcome = resolve_outcome(it);
		awaited_results.push_back(outcome);
		kinds_seen[outcome.result_kind]++;
		items_sent++;
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_OWN_IP)
			station_ip = value[31:0];
		else
			station_mac = value[47:0];
	endtask

	task automatic configure(input logic [63:0] ip_value, input logic [63:0] mac_value);
		settle();
		reg_write(REG_OWN_IP, ip_value);
		reg_write(REG_OWN_MAC, mac_value);
		settings_used++;
	endtask

	task automatic test_reset_defaults();
		send_item(make_lookup(32'h0));
		send_item(make_message(ARP_OP_REQUEST, rand_mac(), $urandom));
	endtask

	task automatic test_message_filter();
		item_t it;
		it = make_message(ARP_OP_REQUEST, 48'h0, 32'h0);
		it.payload_length = ARP_MIN_LEN - 1;
		send_item(it);
		it.payload_length = ARP_MIN_LEN;
		send_item(it);
		it = make_message(ARP_OP_REQUEST, MAC_BCAST, 32'hFFFF_FFFF);
		it.payload_length = 11'h7FF;
		send_item(it);
		it = make_message(ARP_OP_REQUEST, rand_mac(), $urandom);
		it.hw_type = 16'h0000;
		send_item(it);
		it = make_message(ARP_OP_REQUEST, rand_mac(), $urandom);
		it.proto_type = 16'h0008;
		send_item(it);
		it = make_message(ARP_OP_REQUEST, rand_mac(), $urandom);
		it.hw_addr_len = 8'hFF;
		send_item(it);
		it = make_message(ARP_OP_REQUEST, rand_mac(), $urandom);
		it.proto_addr_len = ARP_HW_LEN;
		send_item(it);
		it = make_message(ARP_OP_REQUEST, rand_mac(), $urandom);
		it.target_ip = station_ip ^ 32'h1;
		send_item(it);
		send_item(make_message(16'h0000, rand_mac(), $urandom));
		send_item(make_message(16'h0003, rand_mac(), $urandom));
		send_item(make_message(16'hFFFF, rand_mac(), $urandom));
	endtask

	task automatic test_cache_lookup();
		send_item(make_message(ARP_OP_REPLY, MAC_BCAST, 32'h0A00_0001));
		send_item(make_message(ARP_OP_REPLY, 48'h0200_0000_0001, 32'h0A00_0001));
		send_item(make_message(ARP_OP_REPLY, 48'h0, 32'h0));
		send_item(make_lookup(32'h0A00_0001));
		send_item(make_lookup(32'h0));
		send_item(make_lookup(32'hC0A8_0001));
		send_item(make_lookup(32'hFFFF_FFFF));
	endtask

	task automatic run_traffic_phase(input int quota);
		item_t it;
		int counted;
		int pick;
		logic [15:0] op;
		counted = 0;
		while (counted < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				it = make_message(ARP_OP_REPLY, rand_mac(), pick_ip(15));
			end else if (pick < 45) begin
				it = make_message(ARP_OP_REQUEST, rand_mac(), $urandom);
			end else if (pick < 75) begin
				it = make_lookup($urandom_range(0, 19) == 0 ? station_ip : pick_ip(65));
			end else if (pick < 80) begin
				op = $urandom_range(0, 65535);
				if (op == ARP_OP_REQUEST || op == ARP_OP_REPLY)
					op[8] = 1'b1;
				it = make_message(op, rand_mac(), $urandom);
			end else if (pick < 90) begin
				op = $urandom_range(0, 1) ? ARP_OP_REQUEST : ARP_OP_REPLY;
				it = break_message(make_message(op, rand_mac(), $urandom));
			end else begin
				it = random_item();
			end
			send_item(it);
			counted++;
		end
	endtask

	task automatic test_random_traffic();
		configure({$urandom, $urandom}, {$urandom, $urandom});
		run_traffic_phase(215);
		configure(64'h0, 64'h0);
		run_traffic_phase(215);
		configure({64{1'b1}}, {64{1'b1}});
		run_traffic_phase(215);
		configure({$urandom, $urandom}, {$urandom, $urandom});
		quiet = 1'b1;
		run_traffic_phase(205);
	endtask

	initial begin : calm_windows
		calm = 1'b0;
		forever begin
			repeat (200) @(posedge clk);
			calm <= ($urandom_range(0, 2) == 0);
		end
	end

	initial begin : result_stall
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				$display("%0t ns: result expected none, got kind %0d", $time,
					result_ch.result_kind);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				compare_field("result_kind", want.result_kind, result_ch.result_kind);
				compare_field("send_dest_mac", want.send_dest_mac, result_ch.send_dest_mac);
				compare_field("msg_op", want.msg_op, result_ch.msg_op);
				compare_field("msg_sender_mac", want.msg_sender_mac, result_ch.msg_sender_mac);
				compare_field("msg_sender_ip", want.msg_sender_ip, result_ch.msg_sender_ip);
				compare_field("msg_target_mac", want.msg_target_mac, result_ch.msg_target_mac);
				compare_field("msg_target_ip", want.msg_target_ip, result_ch.msg_target_ip);
				compare_field("resolved_mac", want.resolved_mac, result_ch.resolved_mac);
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count,
			awaited_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.opcode = 1'b0;
		item_ch.payload_length = '0;
		item_ch.hw_type = '0;
		item_ch.proto_type = '0;
		item_ch.hw_addr_len = '0;
		item_ch.proto_addr_len = '0;
		item_ch.arp_op = '0;
		item_ch.sender_mac = '0;
		item_ch.sender_ip = '0;
		item_ch.target_ip = '0;
		item_ch.query_ip = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		configure({64{1'b1}}, {64{1'b1}});
		test_message_filter();
		test_cache_lookup();
		test_random_traffic();
		settle();
		$display("Covered %0d items under %0d register settings: %0d ignored, %0d handled,",
			items_sent, settings_used + 1, kinds_seen[KIND_IGNORED], kinds_seen[KIND_HANDLED]);
		$display("%0d replies sent, %0d lookup hits, %0d requests sent, %0d cache entries.",
			kinds_seen[KIND_REPLY], kinds_seen[KIND_HIT], kinds_seen[KIND_REQUEST],
			known_ips.size());
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_if.sv
rtl/arpc_ctrl.sv
rtl/arpc_dp.sv
rtl/arp_responder_and_cache.sv
rtl/arpc_checker.sv
tb/testbench.sv
